### rtl/note_dispenser_greedy_change_top_macros.svh
// assertion macros shared by the note dispenser rtl
// expects clk and rst in the scope of the module that uses them
`ifndef NOTE_DISPENSER_GREEDY_CHANGE_TOP_MACROS_SVH
`define NOTE_DISPENSER_GREEDY_CHANGE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NDGC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NDGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ndgc_pkg.sv
// shared types and constants for the note dispenser
// no dependencies
package ndgc_pkg;

  localparam int NUM_DENOMS_DEF = 4;
  localparam int NUM_REGS       = 4;
  localparam int AMT_W          = 20;
  localparam int NOTE_W         = 16;
  localparam int CMD_W          = 2;
  localparam int SLOT_W         = 2;
  localparam int STS_W          = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int STEP_W         = $clog2(AMT_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WITHDRAW = 2'd0,
    CMD_DEPOSIT  = 2'd1,
    CMD_QUERY    = 2'd2
  } cmd_t;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_INEXACT   = 2'd1;
  localparam logic [STS_W-1:0] STS_SATURATED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WD_SLOT,
    ST_WD_DIV,
    ST_WD_SUB,
    ST_WD_CHECK,
    ST_WD_EMIT,
    ST_FAIL,
    ST_DEP,
    ST_QRY
  } state_t;

  // divider result toward the sequencer
  typedef struct packed {
    logic              done;
    logic [AMT_W-1:0]  quot;
    logic [NOTE_W-1:0] remd;
  } div_res_t;

endpackage

### rtl/ndgc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on ndgc_pkg
module ndgc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ndgc_pkg::AMT_W-1:0]      dividend,
  input  logic [ndgc_pkg::NOTE_W-1:0]     divisor,
  output ndgc_pkg::div_res_t              res
);

  logic                              busy;
  logic                              done;
  logic [ndgc_pkg::STEP_W-1:0]       step;
  logic [ndgc_pkg::NOTE_W-1:0]       p;
  logic [ndgc_pkg::AMT_W-1:0]        q;
  logic [ndgc_pkg::NOTE_W-1:0]       d;
  logic [ndgc_pkg::NOTE_W:0]         trial;
  logic [ndgc_pkg::NOTE_W:0]         diff;
  logic                              ge;

  // one trial subtract per cycle
  always_comb begin
    trial = {p, q[ndgc_pkg::AMT_W-1]};
    diff  = trial - {1'b0, d};
    ge    = (trial >= {1'b0, d});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= ndgc_pkg::STEP_W'(ndgc_pkg::AMT_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == ndgc_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      p <= '0;
      q <= dividend;
      d <= divisor;
    end else if (busy) begin
      p <= ge ? diff[ndgc_pkg::NOTE_W-1:0] : trial[ndgc_pkg::NOTE_W-1:0];
      q <= {q[ndgc_pkg::AMT_W-2:0], ge};
    end
  end

  assign res.done = done;
  assign res.quot = q;
  assign res.remd = p;

endmodule

### rtl/note_dispenser_greedy_change_top.sv
// withdraw: per nonzero-denomination slot a divider start, the divider steps and the result,
// a subtract step when its stock runs short, a skip per unused slot, a check, then NUM_DENOMS
// words out (a single word when the sum cannot be paid); deposit: one word; query: NUM_DENOMS
// words; one item at a time, in_stall stays high from acceptance until the last word is loaded,
// each word held while out_stall is high
// synchronous reset clears denominations, stock counts, the state, divider control and out_valid
module note_dispenser_greedy_change_top #(
  parameter int NUM_DENOMS = ndgc_pkg::NUM_DENOMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ndgc_pkg::CMD_W-1:0]         cmd,
  input  logic [ndgc_pkg::AMT_W-1:0]         amount,
  input  logic [ndgc_pkg::SLOT_W-1:0]        slot,
  input  logic [ndgc_pkg::NOTE_W-1:0]        notes_in,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ndgc_pkg::STS_W-1:0]         status,
  output logic [ndgc_pkg::SLOT_W-1:0]        slot_out,
  output logic [ndgc_pkg::NOTE_W-1:0]        notes_out,
  output logic                               last,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ndgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ndgc_pkg::NOTE_W-1:0]        cfg_data
);

  `include "note_dispenser_greedy_change_top_macros.svh"

  localparam int IDX_W = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DENOMS - 1);

  ndgc_pkg::state_t                  state, state_next;
  logic [IDX_W-1:0]                  cnt, cnt_next;
  logic [ndgc_pkg::AMT_W-1:0]        rem, rem_next;
  logic [ndgc_pkg::SLOT_W-1:0]       slot_r;
  logic [ndgc_pkg::NOTE_W-1:0]       notes_r;

  logic [ndgc_pkg::NOTE_W-1:0]       denom [ndgc_pkg::NUM_REGS];
  logic [ndgc_pkg::NOTE_W-1:0]       stock [NUM_DENOMS];
  logic [ndgc_pkg::NOTE_W-1:0]       taken [NUM_DENOMS];

  logic                              accept;
  logic [IDX_W-1:0]                  slot_idx;
  logic                              slot_absent;
  logic [IDX_W-1:0]                  rd_idx;
  logic [ndgc_pkg::NOTE_W-1:0]       stock_rd;
  logic [ndgc_pkg::NOTE_W-1:0]       den_cur;
  logic [ndgc_pkg::NOTE_W:0]         dep_sum;
  logic [2*ndgc_pkg::NOTE_W-1:0]     prod;

  logic                              taken_we;
  logic [ndgc_pkg::NOTE_W-1:0]       taken_wd;
  logic                              stk_we;
  logic [ndgc_pkg::NOTE_W-1:0]       stk_wd;

  logic                              emit;
  logic                              out_load;
  logic [ndgc_pkg::STS_W-1:0]        w_status;
  logic [ndgc_pkg::SLOT_W-1:0]       w_slot;
  logic [ndgc_pkg::NOTE_W-1:0]       w_notes;
  logic                              w_last;

  logic                              div_start;
  ndgc_pkg::div_res_t                div_res;

  // shared divider
  ndgc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (den_cur),
    .res      (div_res)
  );

  // handshakes and lookups
  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != ndgc_pkg::ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_load    = !out_valid || !out_stall;
  assign slot_idx    = IDX_W'(slot_r);
  assign slot_absent = (int'(slot_r) >= NUM_DENOMS);
  assign rd_idx      = (state == ndgc_pkg::ST_DEP) ? slot_idx : cnt;
  assign stock_rd    = stock[rd_idx];
  assign den_cur     = (int'(cnt) < ndgc_pkg::NUM_REGS) ? denom[2'(cnt)] : '0;
  assign dep_sum     = {1'b0, stock_rd} + {1'b0, notes_r};
  assign prod        = den_cur * stock_rd;

  // sequencer next state and outputs
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    taken_we   = 1'b0;
    taken_wd   = '0;
    stk_we     = 1'b0;
    stk_wd     = '0;
    emit       = 1'b0;
    w_status   = ndgc_pkg::STS_OK;
    w_slot     = '0;
    w_notes    = '0;
    w_last     = 1'b0;
    div_start  = 1'b0;
    case (state)
      ndgc_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          rem_next = amount;
          case (cmd)
            ndgc_pkg::CMD_WITHDRAW: state_next = ndgc_pkg::ST_WD_SLOT;
            ndgc_pkg::CMD_DEPOSIT:  state_next = ndgc_pkg::ST_DEP;
            default:                state_next = ndgc_pkg::ST_QRY;
          endcase
        end
      end
      ndgc_pkg::ST_WD_SLOT: begin
        if (den_cur == '0) begin
          taken_we = 1'b1;
          taken_wd = '0;
          if (cnt == LAST_IDX) begin
            state_next = ndgc_pkg::ST_WD_CHECK;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end else begin
          div_start  = 1'b1;
          state_next = ndgc_pkg::ST_WD_DIV;
        end
      end
      ndgc_pkg::ST_WD_DIV: begin
        if (div_res.done) begin
          taken_we = 1'b1;
          if (div_res.quot <= {{(ndgc_pkg::AMT_W-ndgc_pkg::NOTE_W){1'b0}}, stock_rd}) begin
            taken_wd = div_res.quot[ndgc_pkg::NOTE_W-1:0];
            rem_next = {{(ndgc_pkg::AMT_W-ndgc_pkg::NOTE_W){1'b0}}, div_res.remd};
            if (cnt == LAST_IDX) begin
              state_next = ndgc_pkg::ST_WD_CHECK;
            end else begin
              cnt_next   = cnt + 1'b1;
              state_next = ndgc_pkg::ST_WD_SLOT;
            end
          end else begin
            taken_wd   = stock_rd;
            state_next = ndgc_pkg::ST_WD_SUB;
          end
        end
      end
      ndgc_pkg::ST_WD_SUB: begin
        // stock runs short: lower the remainder by the whole stock
        rem_next = rem - prod[ndgc_pkg::AMT_W-1:0];
        if (cnt == LAST_IDX) begin
          state_next = ndgc_pkg::ST_WD_CHECK;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ndgc_pkg::ST_WD_SLOT;
        end
      end
      ndgc_pkg::ST_WD_CHECK: begin
        cnt_next   = '0;
        state_next = (rem != '0) ? ndgc_pkg::ST_FAIL : ndgc_pkg::ST_WD_EMIT;
      end
      ndgc_pkg::ST_WD_EMIT: begin
        emit     = 1'b1;
        w_slot   = 2'(cnt);
        w_notes  = taken[cnt];
        w_last   = (cnt == LAST_IDX);
        if (out_load) begin
          stk_we = 1'b1;
          stk_wd = stock_rd - taken[cnt];
          if (cnt == LAST_IDX) begin
            state_next = ndgc_pkg::ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ndgc_pkg::ST_FAIL: begin
        emit     = 1'b1;
        w_status = ndgc_pkg::STS_INEXACT;
        w_last   = 1'b1;
        if (out_load) begin
          state_next = ndgc_pkg::ST_IDLE;
        end
      end
      ndgc_pkg::ST_DEP: begin
        emit   = 1'b1;
        w_slot = slot_r;
        w_last = 1'b1;
        if (!slot_absent) begin
          if (dep_sum[ndgc_pkg::NOTE_W]) begin
            stk_wd   = '1;
            w_status = ndgc_pkg::STS_SATURATED;
          end else begin
            stk_wd = dep_sum[ndgc_pkg::NOTE_W-1:0];
          end
          w_notes = stk_wd;
          stk_we  = out_load;
        end
        if (out_load) begin
          state_next = ndgc_pkg::ST_IDLE;
        end
      end
      ndgc_pkg::ST_QRY: begin
        emit    = 1'b1;
        w_slot  = 2'(cnt);
        w_notes = stock_rd;
        w_last  = (cnt == LAST_IDX);
        if (out_load) begin
          if (cnt == LAST_IDX) begin
            state_next = ndgc_pkg::ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = ndgc_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ndgc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    rem <= rem_next;
    if (accept) begin
      slot_r  <= slot;
      notes_r <= notes_in;
    end
  end

  // denomination registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ndgc_pkg::NUM_REGS; i++) begin
        denom[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (int'(cfg_index) < NUM_DENOMS)) begin
      denom[cfg_index] <= cfg_data;
    end
  end

  // note stock, one write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        stock[i] <= '0;
      end
    end else if (stk_we) begin
      stock[rd_idx] <= stk_wd;
    end
  end

  // notes taken per slot during a withdraw
  always_ff @(posedge clk) begin
    if (taken_we) begin
      taken[cnt] <= taken_wd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_load) begin
      status    <= w_status;
      slot_out  <= w_slot;
      notes_out <= w_notes;
      last      <= w_last;
    end
  end

  // checks
  `NDGC_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "accepted word did not stall input")
  `NDGC_ASSERT_SAME(a_div_done_state, div_res.done, state == ndgc_pkg::ST_WD_DIV, "divider done outside wait")
  `NDGC_ASSERT_SAME(a_no_underflow, state == ndgc_pkg::ST_WD_EMIT, taken[cnt] <= stock_rd, "withdraw exceeds stock")
  `NDGC_ASSERT_SAME(a_fail_word, out_valid && status == ndgc_pkg::STS_INEXACT, last && notes_out == '0, "malformed fail word")

endmodule
